@@ rtl/vtsa_pkg.sv @@
`default_nettype none
package vtsa_pkg;

  localparam int unsigned ANGLE_W = 34;
  localparam int unsigned AZ_W    = 16;
  localparam int unsigned POL_W   = 15;
  localparam int unsigned LEN_W   = 34;
  localparam int unsigned TAB_N   = 32;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // pi and the output angle limit, Q2.30 and Q3.13
  localparam angle_t ANGLE_PI  = 34'sd3373259426;
  localparam angle_t ANGLE_MAX = 34'sd25736;
  localparam angle_t ANGLE_RND = 34'sd65536;

  // atan(2^-i) in Q2.30, truncated
  localparam angle_t ATAN_TAB [TAB_N] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127,
    34'sd63,        34'sd31,        34'sd15,        34'sd7,
    34'sd3,         34'sd1,         34'sd0,         34'sd0
  };

endpackage
`default_nettype wire

@@ rtl/vtsa_sqrt_cell.sv @@
`default_nettype none
module vtsa_sqrt_cell #(
  parameter int unsigned REM_W  = 68,
  parameter int unsigned ROOT_W = 34,
  parameter int unsigned BIT    = 0
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [REM_W-1:0]  rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  output logic      [REM_W-1:0]  rem_o,
  output logic      [ROOT_W-1:0] root_o
);

  localparam int unsigned CW = 2 * ROOT_W + 1;

  logic [CW-1:0]     trial;
  logic              fits;
  logic [REM_W-1:0]  rem_d, rem_q;
  logic [ROOT_W-1:0] root_d, root_q;

  // (r + 2^b)^2 - r^2 = (2r + 2^b) << b
  always_comb begin
    trial  = (CW'(root_i) << (BIT + 1)) | (CW'(1) << (2 * BIT));
    fits   = CW'(rem_i) >= trial;
    rem_d  = fits ? (rem_i - trial[REM_W-1:0]) : rem_i;
    root_d = fits ? (root_i | (ROOT_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

@@ rtl/vtsa_cordic_cell.sv @@
`default_nettype none
module vtsa_cordic_cell #(
  parameter int unsigned XW    = 36,
  parameter int unsigned STAGE = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic signed [XW-1:0]   x_i,
  input  wire logic signed [XW-1:0]   y_i,
  input  wire vtsa_pkg::angle_t       z_i,
  output logic signed [XW-1:0]        x_o,
  output logic signed [XW-1:0]        y_o,
  output vtsa_pkg::angle_t            z_o
);

  logic signed [XW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  vtsa_pkg::angle_t     z_d, z_q;

  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + vtsa_pkg::ATAN_TAB[STAGE];
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - vtsa_pkg::ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule
`default_nettype wire

@@ rtl/vector_to_spherical_angles_top.sv @@
`default_nettype none
// channel | signals                                  | word
// in      | in_valid_i / in_ready_o                  | start_x/y/z_i, end_x/y/z_i
// out     | out_valid_o / out_ready_i                | azimuth, polar, length, zero flag
//
// one word per cycle unless a waiting result stalls the pipeline; stages:
// five setup stages, one sqrt cell per root bit, cordic entry reg,
// one cordic cell per stage, output reg.
// rst_ni clears only valid bits; payload registers are not reset.
// whole pipeline moves when the output register is empty or being taken,
// so input is taken whenever out_ready_i is high or no result is waiting.
module vector_to_spherical_angles_top #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [COORD_WIDTH-1:0] start_x_i,
  input  wire logic [COORD_WIDTH-1:0] start_y_i,
  input  wire logic [COORD_WIDTH-1:0] start_z_i,
  input  wire logic [COORD_WIDTH-1:0] end_x_i,
  input  wire logic [COORD_WIDTH-1:0] end_y_i,
  input  wire logic [COORD_WIDTH-1:0] end_z_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [vtsa_pkg::AZ_W-1:0] azimuth_angle_o,
  output logic [vtsa_pkg::POL_W-1:0]  polar_angle_o,
  output logic [vtsa_pkg::LEN_W-1:0]  vector_length_o,
  output logic                        zero_length_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned MW   = W + 1;
  localparam int unsigned HW   = (MW + 1) / 2;
  localparam int unsigned AW   = MW - HW;
  localparam int unsigned SQW  = 2 * MW;
  localparam int unsigned STW  = SQW + 2;
  localparam int unsigned RW   = W + 2;
  localparam int unsigned XW   = W + 4;
  localparam int unsigned NS   = (CORDIC_STAGES < vtsa_pkg::TAB_N) ? CORDIC_STAGES
                                                                   : vtsa_pkg::TAB_N;
  localparam int unsigned DLN  = 5 + RW;
  localparam int unsigned TOT  = 6 + RW + NS;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
  } diff_t;

  typedef struct packed {
    logic [RW-1:0] len;
    logic          az_zero;
    logic          all_zero;
  } flag_t;

  logic en;
  logic [TOT-1:0] vld_q;
  logic out_valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[TOT-2:0], in_valid_i};
      out_valid_q <= vld_q[TOT-1];
    end
  end

  // differences and their delay line up to the cordic entry
  diff_t diff_d;
  diff_t dline_q [DLN];

  always_comb begin
    diff_d.x = $signed({end_x_i[W-1], end_x_i}) - $signed({start_x_i[W-1], start_x_i});
    diff_d.y = $signed({end_y_i[W-1], end_y_i}) - $signed({start_y_i[W-1], start_y_i});
    diff_d.z = $signed({end_z_i[W-1], end_z_i}) - $signed({start_z_i[W-1], start_z_i});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dline_q[0] <= diff_d;
      for (int k = 1; k < DLN; k++) begin
        dline_q[k] <= dline_q[k-1];
      end
    end
  end

  // squares from half-width partial products; axis 0 x, 1 y, 2 z
  logic [MW-1:0]     mg [3];
  logic [2*AW-1:0]   aa_d [3], aa_q [3];
  logic [AW+HW-1:0]  ab_d [3], ab_q [3];
  logic [2*HW-1:0]   bb_d [3], bb_q [3];
  logic [SQW-1:0]    sq_d [3], sq_q [3];
  logic [STW-1:0]    sxz3_q, dy3_q, sxz4_q, stot4_q;

  always_comb begin
    mg[0] = dline_q[0].x[DW-1] ? MW'(-dline_q[0].x) : MW'(dline_q[0].x);
    mg[1] = dline_q[0].y[DW-1] ? MW'(-dline_q[0].y) : MW'(dline_q[0].y);
    mg[2] = dline_q[0].z[DW-1] ? MW'(-dline_q[0].z) : MW'(dline_q[0].z);
    for (int k = 0; k < 3; k++) begin
      aa_d[k] = (2*AW)'(mg[k][MW-1:HW]) * (2*AW)'(mg[k][MW-1:HW]);
      ab_d[k] = (AW+HW)'(mg[k][MW-1:HW]) * (AW+HW)'(mg[k][HW-1:0]);
      bb_d[k] = (2*HW)'(mg[k][HW-1:0]) * (2*HW)'(mg[k][HW-1:0]);
      sq_d[k] = (SQW'(aa_q[k]) << (2*HW)) + (SQW'(ab_q[k]) << (HW+1)) + SQW'(bb_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        aa_q[k] <= aa_d[k];
        ab_q[k] <= ab_d[k];
        bb_q[k] <= bb_d[k];
        sq_q[k] <= sq_d[k];
      end
      sxz3_q  <= STW'(sq_q[0]) + STW'(sq_q[2]);
      dy3_q   <= STW'(sq_q[1]);
      sxz4_q  <= sxz3_q;
      stot4_q <= sxz3_q + dy3_q;
    end
  end

  // two rows of square-root cells, one root bit per cell
  logic [STW-1:0] rem_xz [RW+1];
  logic [RW-1:0]  root_xz [RW+1];
  logic [STW-1:0] rem_ln [RW+1];
  logic [RW-1:0]  root_ln [RW+1];

  assign rem_xz[0]  = sxz4_q;
  assign root_xz[0] = '0;
  assign rem_ln[0]  = stot4_q;
  assign root_ln[0] = '0;

  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    vtsa_sqrt_cell #(.REM_W(STW), .ROOT_W(RW), .BIT(RW - 1 - j)) u_xz (
      .clk_i (clk_i), .en_i (en),
      .rem_i (rem_xz[j]), .root_i (root_xz[j]),
      .rem_o (rem_xz[j+1]), .root_o (root_xz[j+1])
    );
    vtsa_sqrt_cell #(.REM_W(STW), .ROOT_W(RW), .BIT(RW - 1 - j)) u_ln (
      .clk_i (clk_i), .en_i (en),
      .rem_i (rem_ln[j]), .root_i (root_ln[j]),
      .rem_o (rem_ln[j+1]), .root_o (root_ln[j+1])
    );
  end

  // cordic entry: turn by pi when x is negative
  logic signed [XW-1:0] ax_d, ay_d, px_d, py_d;
  vtsa_pkg::angle_t     az_d, pz_d;
  flag_t                fl_d;
  diff_t                de;

  logic signed [XW-1:0] ax [NS+1], ay [NS+1], px [NS+1], py [NS+1];
  vtsa_pkg::angle_t     az [NS+1], pz [NS+1];
  logic signed [XW-1:0] ax_q, ay_q, px_q, py_q;
  vtsa_pkg::angle_t     az_q, pz_q;
  flag_t                fline_q [NS+1];

  always_comb begin
    de   = dline_q[DLN-1];
    ax_d = XW'(de.x);
    ay_d = XW'(de.z);
    az_d = '0;
    if (ax_d < 0) begin
      az_d = (ay_d >= 0) ? vtsa_pkg::ANGLE_PI : -vtsa_pkg::ANGLE_PI;
      ax_d = -ax_d;
      ay_d = -ay_d;
    end
    px_d = XW'(de.y);
    py_d = $signed(XW'(root_xz[RW]));
    pz_d = '0;
    if (px_d < 0) begin
      pz_d = (py_d >= 0) ? vtsa_pkg::ANGLE_PI : -vtsa_pkg::ANGLE_PI;
      px_d = -px_d;
      py_d = -py_d;
    end
    fl_d.len      = root_ln[RW];
    fl_d.az_zero  = (de.x == '0) && (de.z == '0);
    fl_d.all_zero = fl_d.az_zero && (de.y == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      az_q <= az_d;
      px_q <= px_d;
      py_q <= py_d;
      pz_q <= pz_d;
      fline_q[0] <= fl_d;
      for (int k = 1; k <= NS; k++) begin
        fline_q[k] <= fline_q[k-1];
      end
    end
  end

  assign ax[0] = ax_q;
  assign ay[0] = ay_q;
  assign az[0] = az_q;
  assign px[0] = px_q;
  assign py[0] = py_q;
  assign pz[0] = pz_q;

  for (genvar i = 0; i < NS; i++) begin : g_cordic
    vtsa_cordic_cell #(.XW(XW), .STAGE(i)) u_az (
      .clk_i (clk_i), .en_i (en),
      .x_i (ax[i]), .y_i (ay[i]), .z_i (az[i]),
      .x_o (ax[i+1]), .y_o (ay[i+1]), .z_o (az[i+1])
    );
    vtsa_cordic_cell #(.XW(XW), .STAGE(i)) u_pol (
      .clk_i (clk_i), .en_i (en),
      .x_i (px[i]), .y_i (py[i]), .z_i (pz[i]),
      .x_o (px[i+1]), .y_o (py[i+1]), .z_o (pz[i+1])
    );
  end

  // round Q2.30 to Q3.13 and clamp
  vtsa_pkg::angle_t az_sum, pz_sum, az_r, pz_r;
  logic signed [vtsa_pkg::AZ_W-1:0] az_out_d, az_out_q;
  logic [vtsa_pkg::POL_W-1:0]       pol_out_d, pol_out_q;
  logic [vtsa_pkg::LEN_W-1:0]       len_sat, len_q;
  logic                             zero_q;
  flag_t                            fo;

  assign fo = fline_q[NS];

  always_comb begin
    az_sum = az[NS] + vtsa_pkg::ANGLE_RND;
    pz_sum = pz[NS] + vtsa_pkg::ANGLE_RND;
    az_r   = az_sum >>> 17;
    pz_r   = pz_sum >>> 17;
    if (az_r > vtsa_pkg::ANGLE_MAX) begin
      az_r = vtsa_pkg::ANGLE_MAX;
    end else if (az_r < -vtsa_pkg::ANGLE_MAX) begin
      az_r = -vtsa_pkg::ANGLE_MAX;
    end
    if (pz_r > vtsa_pkg::ANGLE_MAX) begin
      pz_r = vtsa_pkg::ANGLE_MAX;
    end else if (pz_r < 0) begin
      pz_r = '0;
    end
    az_out_d  = fo.az_zero ? '0 : az_r[vtsa_pkg::AZ_W-1:0];
    pol_out_d = fo.all_zero ? '0 : pz_r[vtsa_pkg::POL_W-1:0];
  end

  if (RW > vtsa_pkg::LEN_W) begin : g_len_sat
    assign len_sat = (|fo.len[RW-1:vtsa_pkg::LEN_W]) ? '1 : fo.len[vtsa_pkg::LEN_W-1:0];
  end else begin : g_len_ext
    assign len_sat = vtsa_pkg::LEN_W'(fo.len);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      az_out_q  <= az_out_d;
      pol_out_q <= pol_out_d;
      len_q     <= len_sat;
      zero_q    <= fo.all_zero;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign azimuth_angle_o = az_out_q;
  assign polar_angle_o   = pol_out_q;
  assign vector_length_o = len_q;
  assign zero_length_o   = zero_q;

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_length_o) |-> (vector_length_o == '0 && polar_angle_o == '0))
    else $error("zero-length word with nonzero length or polar angle");

  a_pol_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (polar_angle_o <= vtsa_pkg::POL_W'(25736)))
    else $error("polar angle beyond pi");

  a_az_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (azimuth_angle_o <= 16'sd25736 && azimuth_angle_o >= -16'sd25736))
    else $error("azimuth beyond pi");

endmodule
`default_nettype wire

@@ bench/vector_to_spherical_angles_checker.sv @@
module vector_to_spherical_angles_checker #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [COORD_WIDTH-1:0] start_x_i,
  input  logic [COORD_WIDTH-1:0] start_y_i,
  input  logic [COORD_WIDTH-1:0] start_z_i,
  input  logic [COORD_WIDTH-1:0] end_x_i,
  input  logic [COORD_WIDTH-1:0] end_y_i,
  input  logic [COORD_WIDTH-1:0] end_z_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [15:0]            azimuth_angle_i,
  input  logic [14:0]            polar_angle_i,
  input  logic [33:0]            vector_length_i,
  input  logic                   zero_length_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     words_in_o,
  output int                     words_out_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] az;
    logic [14:0] pol;
    logic [33:0] len;
    logic        zero;
  } angles_t;

  angles_t expected_angles[$];

  function automatic logic signed [63:0] to_signed(logic [COORD_WIDTH-1:0] v);
    logic signed [63:0] r;
    r = 64'(signed'(v));
    return r;
  endfunction

  // floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(logic [127:0] s);
    logic [63:0]  r;
    logic [63:0]  c;
    r = '0;
    for (int b = COORD_WIDTH + 1; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] vector_angle(logic signed [63:0] y,
                                                      logic signed [63:0] x,
                                                      logic signed [63:0] lowest);
    logic signed [63:0] z;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] r;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'(vtsa_pkg::ANGLE_PI) : -64'(vtsa_pkg::ANGLE_PI);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += 64'(vtsa_pkg::ATAN_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= 64'(vtsa_pkg::ATAN_TAB[i]);
      end
    end
    r = (z + 65536) >>> 17;
    if (r > 25736) r = 25736;
    if (r < lowest) r = lowest;
    return r;
  endfunction

  function automatic angles_t predict_angles(logic [COORD_WIDTH-1:0] sx, sy, sz, ex, ey, ez);
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [63:0] dz;
    logic [127:0]       sxz;
    logic [127:0]       sall;
    logic [63:0]        rxz;
    logic [63:0]        len;
    angles_t            a;
    dx = to_signed(ex) - to_signed(sx);
    dy = to_signed(ey) - to_signed(sy);
    dz = to_signed(ez) - to_signed(sz);
    sxz = 128'(dx < 0 ? -dx : dx) * 128'(dx < 0 ? -dx : dx)
        + 128'(dz < 0 ? -dz : dz) * 128'(dz < 0 ? -dz : dz);
    sall = sxz + 128'(dy < 0 ? -dy : dy) * 128'(dy < 0 ? -dy : dy);
    rxz = floor_sqrt(sxz);
    len = floor_sqrt(sall);
    if (len > 64'h3_FFFF_FFFF) len = 64'h3_FFFF_FFFF;
    a.zero = (dx == 0 && dy == 0 && dz == 0);
    a.az = (dx == 0 && dz == 0) ? '0 : 16'(vector_angle(dz, dx, -25736));
    a.pol = a.zero ? '0 : 15'(vector_angle(signed'(rxz), dy, 0));
    a.len = len[33:0];
    return a;
  endfunction

  assign pending_o = expected_angles.size();

  always @(posedge clk_i or negedge rst_ni) begin
    angles_t got;
    angles_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      words_in_o <= 0;
      words_out_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_angles.push_back(predict_angles(start_x_i, start_y_i, start_z_i,
                                                 end_x_i, end_y_i, end_z_i));
        words_in_o <= words_in_o + 1;
      end
      if (out_valid_i && out_ready_i) begin
        words_out_o <= words_out_o + 1;
        got = '{azimuth_angle_i, polar_angle_i, vector_length_i, zero_length_i};
        if (expected_angles.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected word: az %0d pol %0d len %0d zero %0b",
                                          got.az, got.pol, got.len, got.zero);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_angles.pop_front();
          if (got !== want) begin
            if (fail_count_o < 10)
              $display({"mismatch word %0d: exp az %0d pol %0d len %0d zero %0b,",
                        " got az %0d pol %0d len %0d zero %0b"},
                       words_out_o, $signed(want.az), want.pol, want.len, want.zero,
                       $signed(got.az), got.pol, got.len, got.zero);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

@@ bench/vector_to_spherical_angles_top_test.sv @@
module vector_to_spherical_angles_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 32;
  localparam int unsigned LATENCY = 7 + CW + 2 + 16;
  localparam int unsigned RANDOM_WORDS = 1400;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [CW-1:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic [CW-1:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic signed [15:0] azimuth_angle_o;
  logic [14:0]   polar_angle_o;
  logic [33:0]   vector_length_o;
  logic          zero_length_o;
  int            fail_count, pending, words_in, words_out;
  int            idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  vector_to_spherical_angles_top DUT (.*);

  vector_to_spherical_angles_checker #(.COORD_WIDTH(CW)) checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .start_x_i, .start_y_i, .start_z_i, .end_x_i, .end_y_i, .end_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .azimuth_angle_i(azimuth_angle_o), .polar_angle_i(polar_angle_o),
    .vector_length_i(vector_length_o), .zero_length_i(zero_length_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .words_in_o(words_in), .words_out_o(words_out)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 20)) - 10);
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // valid drops only when a gap follows, so back-to-back words keep it high
  task automatic send_word(input logic [CW-1:0] sx, sy, sz, ex, ey, ez);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_x_i <= sx; start_y_i <= sy; start_z_i <= sz;
    end_x_i <= ex; end_y_i <= ey; end_z_i <= ez;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // receiver stalls: phases of free flow and holds of random length
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 199) < 3) repeat ($urandom_range(20, 200)) begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat (gap_len()) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
      $display("vector_to_spherical_angles_top_test NOT OK");
      $finish;
    end
  end

  localparam logic [CW-1:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MAXN = 32'h8000_0000;
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;

  initial begin
    logic [CW-1:0] sx, sy, sz;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    // coinciding points, zero x/z plane, axes and signs, extreme spans
    send_word(0, 0, 0, 0, 0, 0);
    send_word(MAXP, MAXN, 5, MAXP, MAXN, 5);
    send_word(0, 0, 0, 0, ONE, 0);
    send_word(0, 0, 0, 0, -ONE, 0);
    send_word(0, 0, 0, ONE, 0, 0);
    send_word(0, 0, 0, -ONE, 0, 0);
    send_word(0, 0, 0, 0, 0, ONE);
    send_word(0, 0, 0, 0, 0, -ONE);
    send_word(0, 0, 0, -ONE, 0, 1);
    send_word(0, 0, 0, -ONE, 0, -1);
    send_word(0, 0, 0, -ONE, 0, 0);
    send_word(MAXN, MAXN, MAXN, MAXP, MAXP, MAXP);
    send_word(MAXP, MAXP, MAXP, MAXN, MAXN, MAXN);
    send_word(MAXN, 0, 0, MAXP, 0, 0);
    send_word(0, MAXP, 0, 0, MAXN, 0);
    send_word(0, 0, MAXP, 0, 0, MAXN);
    send_word(0, 0, 0, 1, 1, 1);
    send_word(0, 0, 0, -1, -1, -1);
    send_word(0, 0, 0, ONE, ONE, -ONE);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
      case ($urandom_range(0, 9))
        0: send_word(sx, sy, sz, sx, sy, sz);
        1: send_word(sx, sy, sz, sx, rand_coord(), sz);
        default: send_word(sx, sy, sz, rand_coord(), rand_coord(), rand_coord());
      endcase
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    $display("sent %0d vectors and checked %0d results, including coinciding points,",
             words_in, words_out);
    $display("axis-aligned and full-range spans, under random stalls on both sides");
    if (fail_count == 0) $display("vector_to_spherical_angles_top_test OK");
    else $display("vector_to_spherical_angles_top_test NOT OK");
    $finish;
  end
endmodule
